// ===== rtl/sfd_pkg.sv =====
// Shared types and constants for the audio-master video sync frame delay block.
package sfd_pkg;

   // Request operation codes.
   typedef enum logic [2:0] {
      OP_VIDEO_FRAME          = 3'd0,
      OP_SET_AUDIO            = 3'd1,
      OP_ADVANCE_AUDIO        = 3'd2,
      OP_SET_PRESENTATION     = 3'd3,
      OP_ADVANCE_PRESENTATION = 3'd4
   } op_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SYNC_THRESHOLD   = 2'd0,
      CSR_NOSYNC_THRESHOLD = 2'd1,
      CSR_MIN_WAIT         = 2'd2,
      CSR_MAX_WAIT         = 2'd3
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = 27;

   // Request payload.
   typedef struct packed {
      logic [2:0]         operation;
      logic [47:0]        frame_pts_us;
      logic [47:0]        next_pts_us;
      logic [47:0]        now_us;
      logic signed [47:0] amount_us;
   } req_type;

   // Result payload.
   typedef struct packed {
      logic [13:0] wait_ms;
      logic        late;
      logic        capped;
   } rsp_type;

   // Configuration register file.
   typedef struct packed {
      logic [19:0] sync_threshold_us;
      logic [26:0] nosync_threshold_us;
      logic [19:0] min_wait_us;
      logic [23:0] max_wait_us;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      sync_threshold_us:   20'd10000,
      nosync_threshold_us: 27'd10000000,
      min_wait_us:         20'd10000,
      max_wait_us:         24'd600000
   };

   // Updated presentation clock and wall time of one video frame.
   typedef struct packed {
      logic signed [49:0] pres_clock_us;
      logic [47:0]        now_us;
   } frame_type;

   // Bounded wait of one video frame.
   typedef struct packed {
      logic [23:0] wait_us;
      logic        late;
      logic        capped;
   } wait_type;

   // Frame gap limits. Stored gaps always stay below one second, so 20 bits hold them.
   localparam int unsigned        GAP_W        = 20;
   localparam logic signed [48:0] GAP_LIMIT_US = 49'sd1000000;
   localparam logic [GAP_W-1:0]   GAP_RESET_US = 20'd200000;

   // Microseconds to milliseconds: wait * 999 / 1000000. The divide by one million
   // is a shift by 6 followed by a reciprocal multiply for 15625, exact for
   // products below 2^34.
   localparam logic [9:0]  MS_NUMERATOR = 10'd999;
   localparam int unsigned PRE_SHIFT    = 6;
   localparam logic [28:0] RECIP_15625  = 29'd281474977;
   localparam int unsigned RECIP_SHIFT  = 42;
   localparam logic [14:0] WAIT_MS_MAX  = 15'd16383;

endpackage

// ===== rtl/av_sync_frame_delay.sv =====
// Audio-master video sync frame delay: top level with request register and control registers.
//
// Requests arrive on req_valid / req_stall / req_payload. A video-frame request
// updates the presentation clock against the audio clock and yields one result
// on rsp_valid / rsp_stall / rsp_payload: the frame hold time in milliseconds
// with late and capped flags. Clock requests (set or advance the audio or
// presentation clock) and unused operation codes give no result.
// The csr_ port writes the four threshold registers; write only while idle.
// The request register, clock update, wait bound, multiply by 999 and reciprocal
// divide are each registered on the way to the result.
// Throughput: one request per cycle without result stalls; the clock state is
// updated in a single stage, so back-to-back requests see each other's effect.
// Reset (synchronous) clears the clocks and previous timestamp, sets the
// previous gap to 200000 us and restores the register defaults.
// When the receiver stalls, the result holds, the stages behind it fill, and
// req_stall rises only once every stage is occupied.
module av_sync_frame_delay (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sfd_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sfd_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_write_en,
   input  logic [1:0]                        csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]    csr_data
);

   sfd_pkg::cfg_type   cfg_ff, cfg_in;
   logic               req_valid_ff, req_valid_in;
   sfd_pkg::req_type   req_ff, req_in;

   logic               state_ready;
   logic               frame_valid;
   sfd_pkg::frame_type frame;
   logic               wait_ready;
   logic               wait_valid;
   sfd_pkg::wait_type  wait_bound;
   logic               scale_ready;
   logic               req_ready;

   // Control register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (sfd_pkg::csr_index_type'(csr_index))
            sfd_pkg::CSR_SYNC_THRESHOLD:   cfg_in.sync_threshold_us   = csr_data[19:0];
            sfd_pkg::CSR_NOSYNC_THRESHOLD: cfg_in.nosync_threshold_us = csr_data[26:0];
            sfd_pkg::CSR_MIN_WAIT:         cfg_in.min_wait_us         = csr_data[19:0];
            sfd_pkg::CSR_MAX_WAIT:         cfg_in.max_wait_us         = csr_data[23:0];
            default: begin
            end
         endcase
      end
   end

   // Request register.
   assign req_ready = !req_valid_ff || state_ready;
   assign req_stall = !req_ready;

   always_comb begin
      req_in = req_ff;
      if (req_valid && req_ready) begin
         req_valid_in = 1'b1;
         req_in       = req_payload;
      end else if (state_ready) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= sfd_pkg::CFG_RESET;
         req_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   sfd_state u_state (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid_ff),
      .in_ready  (state_ready),
      .in_req    (req_ff),
      .out_valid (frame_valid),
      .out_ready (wait_ready),
      .out_frame (frame)
   );

   sfd_wait u_wait (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (frame_valid),
      .in_ready  (wait_ready),
      .in_frame  (frame),
      .out_valid (wait_valid),
      .out_ready (scale_ready),
      .out_wait  (wait_bound)
   );

   sfd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wait_valid),
      .in_ready  (scale_ready),
      .in_wait   (wait_bound),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_rsp   (rsp_payload)
   );

endmodule

// ===== rtl/sfd_state.sv =====
// Clock state and per-frame presentation clock update stage.
module sfd_state (
   input  logic               clock,
   input  logic               reset,
   input  sfd_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  sfd_pkg::req_type   in_req,
   output logic               out_valid,
   input  logic               out_ready,
   output sfd_pkg::frame_type out_frame
);

   logic signed [48:0]       audio_ff, audio_in;
   logic signed [49:0]       pres_ff, pres_in;
   logic [47:0]              prev_pts_ff, prev_pts_in;
   logic [sfd_pkg::GAP_W-1:0] prev_gap_ff, prev_gap_in;
   logic                     valid_ff, valid_in;
   sfd_pkg::frame_type       frame_ff, frame_in;

   logic                     take;
   logic                     is_video;
   logic signed [48:0]       gap_raw;
   logic                     gap_ok;
   logic [sfd_pkg::GAP_W-1:0] gap_sel;
   logic [sfd_pkg::GAP_W-1:0] sync_us;
   logic signed [50:0]       diff;
   logic signed [50:0]       sync_s;
   logic signed [50:0]       nosync_s;
   logic                     in_window;
   logic [26:0]              adj_gap;
   logic signed [49:0]       pres_sum;
   logic signed [48:0]       amount_a;
   logic signed [49:0]       amount_p;

   // A request moves in when this stage is empty or its frame moves on.
   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign is_video = (in_req.operation == sfd_pkg::OP_VIDEO_FRAME);

   // Frame gap, falling back to the previous gap when it is not in (0, 1 s).
   always_comb begin
      gap_raw = $signed({1'b0, in_req.frame_pts_us}) - $signed({1'b0, prev_pts_ff});
      gap_ok  = (gap_raw > 49'sd0) && (gap_raw < sfd_pkg::GAP_LIMIT_US);
      gap_sel = gap_ok ? gap_raw[sfd_pkg::GAP_W-1:0] : prev_gap_ff;
   end

   // Drift of the next frame against the audio clock and the resulting correction.
   always_comb begin
      diff      = $signed({3'b000, in_req.next_pts_us}) - $signed({{2{audio_ff[48]}}, audio_ff});
      sync_us   = (gap_sel > cfg.sync_threshold_us) ? gap_sel : cfg.sync_threshold_us;
      sync_s    = $signed({31'd0, sync_us});
      nosync_s  = $signed({24'd0, cfg.nosync_threshold_us});
      in_window = (diff > -nosync_s) && (diff < nosync_s);
      if (in_window && (diff <= -sync_s)) begin
         adj_gap = '0;
      end else if (in_window && (diff >= sync_s)) begin
         adj_gap = diff[26:0];
      end else begin
         adj_gap = {7'd0, gap_sel};
      end
      pres_sum = pres_ff + $signed({23'd0, adj_gap});
   end

   // Sign-extended clock amounts.
   assign amount_a = {in_req.amount_us[47], in_req.amount_us};
   assign amount_p = {{2{in_req.amount_us[47]}}, in_req.amount_us};

   // State update for each operation; unused codes change nothing.
   always_comb begin
      audio_in    = audio_ff;
      pres_in     = pres_ff;
      prev_pts_in = prev_pts_ff;
      prev_gap_in = prev_gap_ff;
      if (take) begin
         unique case (in_req.operation)
            sfd_pkg::OP_VIDEO_FRAME: begin
               prev_pts_in = in_req.frame_pts_us;
               prev_gap_in = gap_sel;
               pres_in     = pres_sum;
            end
            sfd_pkg::OP_SET_AUDIO:            audio_in = amount_a;
            sfd_pkg::OP_ADVANCE_AUDIO:        audio_in = audio_ff + amount_a;
            sfd_pkg::OP_SET_PRESENTATION:     pres_in  = amount_p;
            sfd_pkg::OP_ADVANCE_PRESENTATION: pres_in  = pres_ff + amount_p;
            default: begin
            end
         endcase
      end
   end

   // Only video frames go on to the wait stage.
   always_comb begin
      frame_in = frame_ff;
      if (take) begin
         valid_in               = is_video;
         frame_in.pres_clock_us = pres_sum;
         frame_in.now_us        = in_req.now_us;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         audio_ff    <= '0;
         pres_ff     <= '0;
         prev_pts_ff <= '0;
         prev_gap_ff <= sfd_pkg::GAP_RESET_US;
         valid_ff    <= 1'b0;
      end else begin
         audio_ff    <= audio_in;
         pres_ff     <= pres_in;
         prev_pts_ff <= prev_pts_in;
         prev_gap_ff <= prev_gap_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign out_valid = valid_ff;
   assign out_frame = frame_ff;

endmodule

// ===== rtl/sfd_wait.sv =====
// Wait computation stage: presentation clock minus wall time, bounded to the wait window.
module sfd_wait (
   input  logic               clock,
   input  logic               reset,
   input  sfd_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  sfd_pkg::frame_type in_frame,
   output logic               out_valid,
   input  logic               out_ready,
   output sfd_pkg::wait_type  out_wait
);

   logic                 valid_ff, valid_in;
   sfd_pkg::wait_type    wait_ff, wait_in;
   logic                 take;
   logic signed [50:0]   wait_us;
   logic                 late;
   logic                 capped;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // The late test comes first and wins when the bounds conflict.
   always_comb begin
      wait_us = $signed({in_frame.pres_clock_us[49], in_frame.pres_clock_us})
              - $signed({3'b000, in_frame.now_us});
      late    = (wait_us < $signed({31'd0, cfg.min_wait_us}));
      capped  = !late && (wait_us > $signed({27'd0, cfg.max_wait_us}));
   end

   // Bounded wait; within the window it fits in 24 bits.
   always_comb begin
      wait_in = wait_ff;
      if (take) begin
         valid_in       = 1'b1;
         wait_in.late   = late;
         wait_in.capped = capped;
         if (late) begin
            wait_in.wait_us = '0;
         end else if (capped) begin
            wait_in.wait_us = cfg.max_wait_us;
         end else begin
            wait_in.wait_us = wait_us[23:0];
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wait_ff <= wait_in;
   end

   assign out_valid = valid_ff;
   assign out_wait  = wait_ff;

endmodule

// ===== rtl/sfd_scale.sv =====
// Two-stage conversion of the wait from microseconds to milliseconds, with the result register.
module sfd_scale (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sfd_pkg::wait_type in_wait,
   output logic              out_valid,
   input  logic              out_ready,
   output sfd_pkg::rsp_type  out_rsp
);

   localparam logic [33:0] MS_MULT = {24'd0, sfd_pkg::MS_NUMERATOR};

   // Scaled product stage.
   logic        prod_valid_ff, prod_valid_in;
   logic [27:0] prod_ff, prod_in;
   logic        late_ff, late_in;
   logic        capped_ff, capped_in;
   // Result stage.
   logic             rsp_valid_ff, rsp_valid_in;
   sfd_pkg::rsp_type rsp_ff, rsp_in;

   logic        prod_ready;
   logic        take_in;
   logic        take_prod;
   logic [33:0] scaled;
   logic [56:0] recip;
   logic [14:0] quot;

   assign prod_ready = !rsp_valid_ff || out_ready;
   assign in_ready   = !prod_valid_ff || prod_ready;
   assign take_in    = in_valid && in_ready;
   assign take_prod  = prod_valid_ff && prod_ready;

   // Multiply by 999, then drop the six low bits of the million divisor.
   always_comb begin
      scaled    = in_wait.wait_us * MS_MULT;
      prod_in   = prod_ff;
      late_in   = late_ff;
      capped_in = capped_ff;
      if (take_in) begin
         prod_valid_in = 1'b1;
         prod_in       = scaled[33:sfd_pkg::PRE_SHIFT];
         late_in       = in_wait.late;
         capped_in     = in_wait.capped;
      end else if (prod_ready) begin
         prod_valid_in = 1'b0;
      end else begin
         prod_valid_in = prod_valid_ff;
      end
   end

   // Divide by 15625 through the reciprocal and saturate to the field width.
   always_comb begin
      recip  = {29'd0, prod_ff} * {28'd0, sfd_pkg::RECIP_15625};
      quot   = recip[56:sfd_pkg::RECIP_SHIFT];
      rsp_in = rsp_ff;
      if (take_prod) begin
         rsp_valid_in   = 1'b1;
         rsp_in.wait_ms = (quot > sfd_pkg::WAIT_MS_MAX) ? sfd_pkg::WAIT_MS_MAX[13:0] : quot[13:0];
         rsp_in.late    = late_ff;
         rsp_in.capped  = capped_ff;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      late_ff   <= late_in;
      capped_ff <= capped_in;
      rsp_ff    <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ===== verif/tb_av_sync_frame_delay.sv =====
// Self-checking testbench for the audio-master video sync frame delay block.
`timescale 1ns / 1ps

module tb_av_sync_frame_delay;

   localparam longint FRAME_GAP_LIMIT = 1000000;
   localparam longint MS_SCALE_NUM    = 999;
   localparam longint MS_SCALE_DEN    = 1000000;
   localparam longint WAIT_MS_CEILING = 16383;
   localparam int     DRAIN_CYCLES    = 12;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   sfd_pkg::req_type               req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   sfd_pkg::rsp_type               rsp_payload;
   logic                           csr_write_en = 1'b0;
   logic [1:0]                     csr_index = '0;
   logic [sfd_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Requests waiting to be offered and frame delays still to arrive.
   sfd_pkg::req_type pending_requests[$];
   sfd_pkg::rsp_type expected_delays[$];
   int      queued_items = 0;
   int      fail_count = 0;

   // Traffic shaping knobs, set by the sequence below.
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   recv_hold_left = 0;
   logic send_hold = 1'b0;
   logic req_taken = 1'b0;

   // Predictor state at the block's widths, but for a 21-bit frame gap.
   sfd_pkg::cfg_type   model_limits = sfd_pkg::CFG_RESET;
   logic signed [48:0] audio_clock_us = '0;
   logic signed [49:0] pres_clock_us = '0;
   logic [47:0]        last_frame_pts = '0;
   logic [20:0]        last_frame_gap = 21'd200000;

   av_sync_frame_delay dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Apply one accepted request to the predictor; video frames yield a delay.
   task automatic predict_frame_delay(input sfd_pkg::req_type r);
      longint  amount, total, gap, drift, sync_span, nosync_span;
      longint  wait_us, floor_us, ceiling_us, hold_ms;
      sfd_pkg::rsp_type due;
      amount = longint'(r.amount_us);
      due = '0;
      case (r.operation)
         sfd_pkg::OP_SET_AUDIO: begin
            audio_clock_us = amount[48:0];
         end
         sfd_pkg::OP_ADVANCE_AUDIO: begin
            total = longint'(audio_clock_us);
            total += amount;
            audio_clock_us = total[48:0];
         end
         sfd_pkg::OP_SET_PRESENTATION: begin
            pres_clock_us = amount[49:0];
         end
         sfd_pkg::OP_ADVANCE_PRESENTATION: begin
            total = longint'(pres_clock_us);
            total += amount;
            pres_clock_us = total[49:0];
         end
         sfd_pkg::OP_VIDEO_FRAME: begin
            // Frame gap, falling back to the last good one outside (0, 1 s).
            gap = longint'(r.frame_pts_us) - longint'(last_frame_pts);
            if (gap <= 0 || gap >= FRAME_GAP_LIMIT) begin
               gap = longint'(last_frame_gap);
            end
            last_frame_pts = r.frame_pts_us;
            last_frame_gap = gap[20:0];

            // Correct toward the audio clock inside the no-sync window.
            total = longint'(audio_clock_us);
            drift = longint'(r.next_pts_us) - total;
            sync_span = longint'(model_limits.sync_threshold_us);
            if (gap > sync_span) begin
               sync_span = gap;
            end
            nosync_span = longint'(model_limits.nosync_threshold_us);
            if (drift > -nosync_span && drift < nosync_span) begin
               if (drift <= -sync_span) begin
                  gap = 0;
               end else if (drift >= sync_span) begin
                  gap = drift;
               end
            end
            total = longint'(pres_clock_us);
            total += gap;
            pres_clock_us = total[49:0];

            // Bound the wait; the late test wins over the cap.
            total = longint'(pres_clock_us);
            wait_us = total - longint'(r.now_us);
            floor_us = longint'(model_limits.min_wait_us);
            ceiling_us = longint'(model_limits.max_wait_us);
            if (wait_us < floor_us) begin
               due.late = 1'b1;
            end else begin
               if (wait_us > ceiling_us) begin
                  wait_us = ceiling_us;
                  due.capped = 1'b1;
               end
               hold_ms = wait_us * MS_SCALE_NUM / MS_SCALE_DEN;
               if (hold_ms > WAIT_MS_CEILING) begin
                  hold_ms = WAIT_MS_CEILING;
               end
               due.wait_ms = hold_ms[13:0];
            end
            expected_delays.push_back(due);
         end
         default: ;
      endcase
   endtask

   function automatic logic [47:0] rand48();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[47:0];
   endfunction

   task automatic queue_request(input logic [2:0] op, input logic [47:0] frame_pts,
                                input logic [47:0] next_pts, input logic [47:0] now_at,
                                input logic [47:0] amount);
      sfd_pkg::req_type item;
      item.operation = op;
      item.frame_pts_us = frame_pts;
      item.next_pts_us = next_pts;
      item.now_us = now_at;
      item.amount_us = amount;
      pending_requests.push_back(item);
      if (op <= sfd_pkg::OP_ADVANCE_PRESENTATION) begin
         queued_items++;
      end
   endtask

   // A plausible playback stream: clocks set near the first timestamp, then
   // frames at a steady rate with jitter, drops, repeats and seeks, while the
   // audio clock drifts by small, large and out-of-window amounts.
   task automatic queue_stream(input int frames);
      longint origin, pts, audio_est, step, now_at, lead, base_t, shift;
      int     jitter, drift;
      origin = longint'($urandom);
      origin = origin << $urandom_range(0, 14);
      case ($urandom_range(0, 3))
         0: step = 33367;
         1: step = 40000;
         2: step = 16683;
         default: step = longint'($urandom_range(2000, 120000));
      endcase
      pts = origin;
      audio_est = origin;
      shift = origin + longint'($urandom_range(0, 50000));
      queue_request(sfd_pkg::OP_SET_AUDIO, rand48(), rand48(), rand48(), origin[47:0]);
      queue_request(sfd_pkg::OP_SET_PRESENTATION, rand48(), rand48(), rand48(), shift[47:0]);
      for (int k = 0; k < frames; k++) begin
         jitter = $urandom_range(0, 1000);
         jitter -= 500;
         case ($urandom_range(0, 19))
            0: ;
            1: pts += longint'(1000000 + $urandom_range(0, 2000000));
            2: pts -= step;
            3: pts += 2 * step;
            default: pts += step + longint'(jitter);
         endcase
         if (pts < 0) begin
            pts = 0;
         end

         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  drift = $urandom_range(0, 30000);
                  drift -= 15000;
               end
               6, 7: begin
                  drift = $urandom_range(0, 600000);
                  drift -= 300000;
               end
               8: begin
                  drift = $urandom_range(0, 60000000);
                  drift -= 30000000;
               end
               default: drift = 0;
            endcase
            audio_est += step + longint'(drift);
            shift = step + longint'(drift);
            queue_request(sfd_pkg::OP_ADVANCE_AUDIO, rand48(), rand48(), rand48(), shift[47:0]);
         end
         if ($urandom_range(0, 29) == 0) begin
            audio_est = pts;
            queue_request(sfd_pkg::OP_SET_AUDIO, rand48(), rand48(), rand48(), pts[47:0]);
         end
         if ($urandom_range(0, 19) == 0) begin
            jitter = $urandom_range(0, 100000);
            shift = longint'(jitter) - 50000;
            queue_request(sfd_pkg::OP_ADVANCE_PRESENTATION, rand48(), rand48(), rand48(),
                          shift[47:0]);
         end

         // Wall time spread so that waits land late, in range and capped.
         lead = longint'($urandom_range(0, 1000000));
         lead -= 60000;
         base_t = ($urandom_range(0, 1) == 1) ? audio_est : pts;
         now_at = base_t + step - lead;
         if (now_at < 0) begin
            now_at = 0;
         end
         shift = pts + step;
         queue_request(sfd_pkg::OP_VIDEO_FRAME, pts[47:0], shift[47:0], now_at[47:0],
                       rand48());
      end
   endtask

   // Mostly streams, the rest unrelated requests with random fields.
   task automatic offer_traffic(input int count);
      int goal;
      goal = queued_items + count;
      while (queued_items < goal) begin
         if ($urandom_range(0, 4) == 0) begin
            queue_request(3'($urandom_range(0, 7)), rand48(), rand48(), rand48(), rand48());
         end else begin
            queue_stream($urandom_range(8, 40));
         end
      end
   endtask

   // Wait until every request is in and every delay is out, then let
   // clock requests still in the pipeline settle.
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_delays.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input sfd_pkg::csr_index_type idx,
                            input logic [sfd_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         sfd_pkg::CSR_SYNC_THRESHOLD:   model_limits.sync_threshold_us = value[19:0];
         sfd_pkg::CSR_NOSYNC_THRESHOLD: model_limits.nosync_threshold_us = value[26:0];
         sfd_pkg::CSR_MIN_WAIT:         model_limits.min_wait_us = value[19:0];
         sfd_pkg::CSR_MAX_WAIT:         model_limits.max_wait_us = value[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic apply_limits(input logic [sfd_pkg::CSR_DATA_W-1:0] sync_us,
                               input logic [sfd_pkg::CSR_DATA_W-1:0] nosync_us,
                               input logic [sfd_pkg::CSR_DATA_W-1:0] min_us,
                               input logic [sfd_pkg::CSR_DATA_W-1:0] max_us);
      write_csr(sfd_pkg::CSR_SYNC_THRESHOLD, sync_us);
      write_csr(sfd_pkg::CSR_NOSYNC_THRESHOLD, nosync_us);
      write_csr(sfd_pkg::CSR_MIN_WAIT, min_us);
      write_csr(sfd_pkg::CSR_MAX_WAIT, max_us);
   endtask

   // Request driver: a request stays up with the same payload until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (!send_hold && pending_requests.size() != 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_payload <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall: random, or held for a counted stretch.
   always @(negedge clock) begin
      if (recv_hold_left > 0) begin
         rsp_stall <= 1'b1;
         recv_hold_left <= recv_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Predict on each accepted request and check each accepted result.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_frame_delay(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_delays.size() == 0) begin
               $error("result with no request pending: wait_ms %0d late %0b capped %0b",
                      rsp_payload.wait_ms, rsp_payload.late, rsp_payload.capped);
               fail_count++;
            end else begin
               if (rsp_payload.wait_ms !== expected_delays[0].wait_ms) begin
                  $error("wait_ms: expected %0d, got %0d",
                         expected_delays[0].wait_ms, rsp_payload.wait_ms);
                  fail_count++;
               end
               if (rsp_payload.late !== expected_delays[0].late) begin
                  $error("late: expected %0b, got %0b",
                         expected_delays[0].late, rsp_payload.late);
                  fail_count++;
               end
               if (rsp_payload.capped !== expected_delays[0].capped) begin
                  $error("capped: expected %0b, got %0b",
                         expected_delays[0].capped, rsp_payload.capped);
                  fail_count++;
               end
               void'(expected_delays.pop_front());
            end
         end
      end
   end

   // Sequence of phases, each with its own limits and traffic shape.
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests under the reset limits: plain wait, lead, lag,
      // gap fallbacks (repeat, backwards, over one second), drift beyond the
      // no-sync window, exact lead and lag bounds, both wait bounds.
      queue_request(sfd_pkg::OP_VIDEO_FRAME, 48'd0, 48'd0, 48'd0, 48'd0);
      queue_request(sfd_pkg::OP_VIDEO_FRAME, 48'd40000, 48'd80000, 48'd0, 48'd0);
      queue_request(sfd_pkg::OP_SET_AUDIO, 48'd0, 48'd0, 48'd0, 48'd5000000);
      queue_request(sfd_pkg::OP_VIDEO_FRAME, 48'd80000, 48'd120000, 48'd400000, 48'd0);
      queue_request(sfd_pkg::OP_VIDEO_FRAME, 48'd80000, 48'd5005000, 48'd0, 48'd0);
      queue_request(sfd_pkg::OP_VIDEO_FRAME, 48'd30000, 48'd25000000, 48'd0, 48'd0);
      queue_request(sfd_pkg::OP_VIDEO_FRAME, 48'd2000000, 48'd5000000, 48'd0, 48'd0);
      queue_request(sfd_pkg::OP_SET_PRESENTATION, 48'd0, 48'd0, 48'd0, 48'd5000000);
      queue_request(sfd_pkg::OP_VIDEO_FRAME, 48'd2040000, 48'd5040000, 48'd1000000, 48'd0);
      queue_request(sfd_pkg::OP_VIDEO_FRAME, 48'd2080000, 48'd4960000, 48'd5000000, 48'd0);
      queue_request(sfd_pkg::OP_VIDEO_FRAME, 48'd2120000, 48'd5000000, 48'd5070001, 48'd0);
      queue_request(sfd_pkg::OP_VIDEO_FRAME, 48'd2160000, 48'd5000000, 48'd5110000, 48'd0);
      queue_request(sfd_pkg::OP_VIDEO_FRAME, 48'd2200000, 48'd5000000, 48'd4560000, 48'd0);
      queue_request(sfd_pkg::OP_VIDEO_FRAME, 48'd2240000, 48'd5000000, 48'd4599999, 48'd0);
      // Clock wrap in both directions and the widest field values.
      queue_request(sfd_pkg::OP_SET_AUDIO, 48'd0, 48'd0, 48'd0, 48'h7FFF_FFFF_FFFF);
      queue_request(sfd_pkg::OP_ADVANCE_AUDIO, 48'd0, 48'd0, 48'd0, 48'h7FFF_FFFF_FFFF);
      queue_request(sfd_pkg::OP_ADVANCE_AUDIO, 48'd0, 48'd0, 48'd0, 48'h8000_0000_0000);
      queue_request(sfd_pkg::OP_SET_PRESENTATION, 48'd0, 48'd0, 48'd0, 48'h7FFF_FFFF_FFFF);
      repeat (4) begin
         queue_request(sfd_pkg::OP_ADVANCE_PRESENTATION, 48'd0, 48'd0, 48'd0,
                       48'h7FFF_FFFF_FFFF);
      end
      queue_request(sfd_pkg::OP_VIDEO_FRAME, '1, '1, '1, '1);
      queue_request(3'd5, '1, '1, '1, '1);
      queue_request(3'd7, '1, '1, '1, '1);
      offer_traffic(250);
      wait_drained();

      // Nominal limits, sender often idle.
      apply_limits(27'd10000, 27'd10000000, 27'd10000, 27'd600000);
      send_idle_pct = 56;
      offer_traffic(300);
      wait_drained();

      // All limits at zero, receiver often stalled.
      apply_limits(27'd0, 27'd0, 27'd0, 27'd0);
      send_idle_pct = 0;
      recv_stall_pct = 56;
      offer_traffic(300);
      wait_drained();

      // All limits at full register width; the cap can pass the output range.
      apply_limits(27'hFFFFF, 27'h7FFFFFF, 27'hFFFFF, 27'hFFFFFF);
      send_idle_pct = 15;
      recv_stall_pct = 15;
      offer_traffic(300);
      wait_drained();

      // Minimum above maximum; receiver holds off long enough to back up the block.
      apply_limits(27'd40000, 27'd100000000, 27'd800000, 27'd100000);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      offer_traffic(300);
      @(posedge clock);
      recv_hold_left = 150;
      wait_drained();

      // Top of the stated ranges; sender pauses midway until all delays are in.
      apply_limits(27'd1000000, 27'd100000000, 27'd0, 27'd10000000);
      recv_stall_pct = 56;
      offer_traffic(300);
      while (pending_requests.size() > 150) @(posedge clock);
      send_hold = 1'b1;
      while (req_valid || expected_delays.size() != 0) @(posedge clock);
      send_hold = 1'b0;
      wait_drained();

      // Random limits, light idling on both sides.
      apply_limits(27'($urandom_range(0, 1000000)), 27'($urandom_range(0, 100000000)),
                   27'($urandom_range(0, 100000)), 27'($urandom_range(0, 10000000)));
      send_idle_pct = 15;
      recv_stall_pct = 15;
      offer_traffic(300);
      wait_drained();

      if (expected_delays.size() != 0) begin
         $error("%0d frame delays never arrived", expected_delays.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Run limit well above the slowest correct run.
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sfd_pkg.sv
rtl/sfd_state.sv
rtl/sfd_wait.sv
rtl/sfd_scale.sv
rtl/av_sync_frame_delay.sv
verif/tb_av_sync_frame_delay.sv
